// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check a condition that must hold on the next edge.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/mjsw_pkg.sv -----
// Package for the maze junction stack walker: types, codes and defaults.
package mjsw_pkg;
  localparam int ROWS_DEF = 8;
  localparam int COLS_DEF = 8;
  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PLACE = 2'd1;
  localparam logic [1:0] OP_MOVE  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [2:0] CELL_OPEN     = 3'd0;
  localparam logic [2:0] CELL_WALL     = 3'd1;
  localparam logic [2:0] CELL_JUNCTION = 3'd2;
  localparam logic [2:0] CELL_START    = 3'd3;
  localparam logic [2:0] CELL_EXIT     = 3'd4;

  localparam logic [2:0] DIR_UP    = 3'd0;
  localparam logic [2:0] DIR_DOWN  = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic [2:0] DIR_NONE  = 3'd4;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_FULL  = 2'd1;
  localparam logic [1:0] FAULT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] cell_row;
    logic [2:0] cell_col;
    logic [2:0] cell_code;
  } req_t;

  typedef struct packed {
    logic [2:0]  pos_row;
    logic [2:0]  pos_col;
    logic [2:0]  moved_dir;
    logic [15:0] move_total;
    logic        at_exit;
    logic [4:0]  stack_level;
    logic [1:0]  fault;
  } rsp_t;

  // Probe order: left, up, down, right.
  function automatic logic [2:0] probe_dir(input logic [1:0] i);
    case (i)
      2'd0: probe_dir = DIR_LEFT;
      2'd1: probe_dir = DIR_UP;
      2'd2: probe_dir = DIR_DOWN;
      default: probe_dir = DIR_RIGHT;
    endcase
  endfunction
endpackage

// ----- rtl/mjsw_ram.sv -----
// Generic RAM with one write port and one registered read port.
module mjsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/maze_junction_stack_walker_core.sv -----
// Top level of the maze junction stack walker: sequencer, state and ports.
//
// Usage:
//   Requests enter on in_valid/in_stall with an mjsw_pkg::req_t payload
//   (op, cell_row, cell_col, cell_code). Every request yields one result on
//   out_valid/out_stall with an mjsw_pkg::rsp_t payload. One request is
//   worked at a time; in_stall stays high until the sequencer is idle.
//   All maze access goes through the single maze RAM read port, whose read
//   is registered, so each cell read takes an address state and a wait
//   state; that port sets the timing. A place reads every maze cell; a move
//   reads its own cell, then probes each neighbor unless on the exit cell.
//   The sequencer goes idle as a result is registered, then takes the
//   next request.
//   While out_stall is high the result register holds its value; the next
//   request may still be worked, and its result waits in the sequencer
//   with in_stall high until the register frees up.
//   Reset clears the walker position, direction, stack pointer and move
//   counter; maze and stack contents are undefined until written.
module maze_junction_stack_walker_core #(
  parameter int ROWS = mjsw_pkg::ROWS_DEF,
  parameter int COLS = mjsw_pkg::COLS_DEF,
  parameter int STACK_DEPTH = mjsw_pkg::STACK_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  mjsw_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mjsw_pkg::rsp_t out_data
);
  import mjsw_pkg::*;
`include "assert_macros.svh"

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int CELLS = ROWS * COLS;
  localparam int AW = $clog2(CELLS);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);
  // Stack entry: row, col, four explored flags, target direction.
  localparam int EW = RW + CW + 4 + 3;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_LOAD  = 15'b000000000000010,
    S_SCAN  = 15'b000000000000100,
    S_SCANW = 15'b000000000001000,
    S_PLACE = 15'b000000000010000,
    S_CUR   = 15'b000000000100000,
    S_CURW  = 15'b000000001000000,
    S_PROBE = 15'b000000010000000,
    S_PRBW  = 15'b000000100000000,
    S_DEC   = 15'b000001000000000,
    S_BKW   = 15'b000010000000000,
    S_BACK  = 15'b000100000000000,
    S_EXIT  = 15'b001000000000000,
    S_EXITW = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  state_t state;
  req_t   req;
  logic [RW-1:0] walker_row;
  logic [CW-1:0] walker_col;
  logic [2:0]    last_dir;
  logic [PW-1:0] stack_pointer;
  logic [15:0]   move_counter;
  logic [2:0]    moved;
  logic [1:0]    fault;
  logic [2:0]    cur_code;
  logic [1:0]    probe_idx;
  logic [3:0]    pass_mask;   // indexed by direction code
  logic [3:0]    junc_mask;   // neighbor is a junction
  logic [RW-1:0] scan_row;
  logic [CW-1:0] scan_col;
  logic          scan_found;
  logic [RW-1:0] found_row;
  logic [CW-1:0] found_col;
  logic          exit_flag;
  rsp_t          rsp;

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
    logic [2*AW-1:0] a;
    a = (2*AW)'(r) * (2*AW)'(COLS) + (2*AW)'(c);
    return a[AW-1:0];
  endfunction

  function automatic logic [3:0] top_expl_marked(input logic [3:0] e, input logic [2:0] t);
    logic [3:0] r;
    r = e;
    if (t < DIR_NONE) r[t[1:0]] = 1'b1;
    return r;
  endfunction

  // Maze RAM.
  logic          m_we;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [2:0]    m_rdata;

  mjsw_ram #(.WIDTH(3), .DEPTH(CELLS)) u_maze (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(req.cell_code),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  // Stack RAM.
  logic          s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [EW-1:0] s_wdata, s_rdata;

  mjsw_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  logic [RW-1:0] top_row;
  logic [CW-1:0] top_col;
  logic [3:0]    top_expl;
  logic [2:0]    top_tgt;
  assign {top_row, top_col, top_expl, top_tgt} = s_rdata;
  assign s_raddr = SW'(stack_pointer - PW'(1));

  // Neighbor of the walker in the direction under probe.
  logic [2:0]    pdir;
  logic          p_on;
  logic [RW-1:0] p_row;
  logic [CW-1:0] p_col;
  assign pdir = probe_dir(probe_idx);

  always_comb begin
    p_row = walker_row;
    p_col = walker_col;
    p_on  = 1'b1;
    case (pdir)
      DIR_UP: begin
        p_on = (walker_row != '0);
        p_row = walker_row - RW'(1);
      end
      DIR_DOWN: begin
        p_on = ({1'b0, walker_row} + (RW+1)'(1)) < (RW+1)'(ROWS);
        p_row = walker_row + RW'(1);
      end
      DIR_LEFT: begin
        p_on = (walker_col != '0);
        p_col = walker_col - CW'(1);
      end
      default: begin
        p_on = ({1'b0, walker_col} + (CW+1)'(1)) < (CW+1)'(COLS);
        p_col = walker_col + CW'(1);
      end
    endcase
  end

  // Maze read address and write control; drop loads beyond the maze.
  always_comb begin
    m_we    = (state == S_LOAD) && (32'(req.cell_row) < 32'(ROWS))
              && (32'(req.cell_col) < 32'(COLS));
    m_waddr = addr_of(RW'(req.cell_row), CW'(req.cell_col));
    case (state)
      S_SCAN:  m_raddr = addr_of(scan_row, scan_col);
      S_PROBE: m_raddr = addr_of(p_row, p_col);
      default: m_raddr = addr_of(walker_row, walker_col);
    endcase
  end

  // Move decision from the gathered masks; the first probe in order wins.
  logic [2:0] choice;
  logic       on_junc;
  logic [2:0] ch_step;
  always_comb begin
    on_junc = (cur_code == CELL_JUNCTION) && (stack_pointer != '0);
    choice  = DIR_NONE;
    ch_step = DIR_NONE;
    for (int i = 3; i >= 0; i--) begin
      ch_step = probe_dir(2'(i));
      if (pass_mask[ch_step[1:0]]) begin
        if (on_junc) begin
          if (top_tgt != ch_step && !top_expl[ch_step[1:0]]) choice = ch_step;
        end else if (last_dir != (ch_step ^ 3'd1)) begin
          choice = ch_step;
        end
      end
    end
  end

  // Position of the chosen neighbor.
  logic [RW-1:0] c_row;
  logic [CW-1:0] c_col;
  always_comb begin
    c_row = walker_row;
    c_col = walker_col;
    case (choice)
      DIR_UP:    c_row = walker_row - RW'(1);
      DIR_DOWN:  c_row = walker_row + RW'(1);
      DIR_LEFT:  c_col = walker_col - CW'(1);
      default:   c_col = walker_col + CW'(1);
    endcase
  end

  logic [3:0] push_expl;
  always_comb begin
    push_expl = '0;
    push_expl[choice[1:0] ^ 2'd1] = 1'b1;
  end

  logic do_push;
  logic stack_full;
  logic [PW-1:0] sp_after;
  assign do_push = !on_junc && choice != DIR_NONE && junc_mask[choice[1:0]];
  assign stack_full = (stack_pointer == PW'(STACK_DEPTH));
  // A junction with nothing left to explore pops itself.
  assign sp_after = on_junc ? stack_pointer - PW'(1) : stack_pointer;

  always_comb begin
    s_we    = 1'b0;
    s_waddr = s_raddr;
    s_wdata = {top_row, top_col, top_expl, choice};
    if (state == S_DEC) begin
      if (on_junc && choice != DIR_NONE) begin
        s_we = 1'b1;
      end else if (do_push && !stack_full) begin
        s_we = 1'b1;
        s_waddr = SW'(stack_pointer);
        s_wdata = {c_row, c_col, push_expl, DIR_NONE};
      end
    end else if (state == S_BACK) begin
      // Backtrack: mark the target of the new top explored.
      s_we = (top_tgt < DIR_NONE);
      s_wdata = {top_row, top_col, top_expl_marked(top_expl, top_tgt), top_tgt};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      walker_row <= '0;
      walker_col <= '0;
      last_dir <= DIR_NONE;
      stack_pointer <= '0;
      move_counter <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            moved <= DIR_NONE;
            fault <= FAULT_NONE;
            case (in_data.op)
              OP_LOAD: state <= S_LOAD;
              OP_PLACE: begin
                state <= S_SCAN;
                scan_row <= '0;
                scan_col <= '0;
                scan_found <= 1'b0;
              end
              OP_MOVE: state <= S_CUR;
              default: state <= S_EXIT;
            endcase
          end
        end
        S_LOAD: state <= S_EXIT;
        S_SCAN: state <= S_SCANW;
        S_SCANW: begin
          if (!scan_found && m_rdata == CELL_START) begin
            scan_found <= 1'b1;
            found_row <= scan_row;
            found_col <= scan_col;
          end
          if (scan_col == CW'(COLS - 1)) begin
            scan_col <= '0;
            if (scan_row == RW'(ROWS - 1)) begin
              state <= S_PLACE;
            end else begin
              scan_row <= scan_row + RW'(1);
              state <= S_SCAN;
            end
          end else begin
            scan_col <= scan_col + CW'(1);
            state <= S_SCAN;
          end
        end
        S_PLACE: begin
          walker_row <= scan_found ? found_row : RW'(ROWS - 1);
          walker_col <= scan_found ? found_col : '0;
          last_dir <= DIR_NONE;
          stack_pointer <= '0;
          move_counter <= '0;
          state <= S_EXIT;
        end
        S_CUR: state <= S_CURW;
        S_CURW: begin
          cur_code <= m_rdata;
          probe_idx <= '0;
          pass_mask <= '0;
          junc_mask <= '0;
          // Hold still on the exit cell.
          state <= (m_rdata == CELL_EXIT) ? S_EXIT : S_PROBE;
        end
        S_PROBE: state <= S_PRBW;
        S_PRBW: begin
          pass_mask[pdir[1:0]] <= p_on && m_rdata != CELL_WALL;
          junc_mask[pdir[1:0]] <= p_on && m_rdata == CELL_JUNCTION;
          probe_idx <= probe_idx + 2'd1;
          state <= (probe_idx == 2'd3) ? S_DEC : S_PROBE;
        end
        S_DEC: begin
          if (choice != DIR_NONE) begin
            walker_row <= c_row;
            walker_col <= c_col;
            last_dir <= choice;
            moved <= choice;
            if (move_counter != 16'hFFFF) move_counter <= move_counter + 16'd1;
            if (do_push) begin
              if (!stack_full) stack_pointer <= stack_pointer + PW'(1);
              else fault <= FAULT_FULL;
            end
            state <= S_EXIT;
          end else begin
            stack_pointer <= sp_after;
            if (sp_after == '0) begin
              fault <= FAULT_EMPTY;
              state <= S_EXIT;
            end else begin
              state <= S_BKW;  // wait for the new top to be read
            end
          end
        end
        S_BKW: state <= S_BACK;
        S_BACK: begin
          walker_row <= top_row;
          walker_col <= top_col;
          if (move_counter != 16'hFFFF) move_counter <= move_counter + 16'd1;
          state <= S_EXIT;
        end
        // Re-read the walker cell for at_exit.
        S_EXIT: state <= S_EXITW;
        S_EXITW: begin
          exit_flag <= (m_rdata == CELL_EXIT);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        rsp.pos_row <= 3'(walker_row);
        rsp.pos_col <= 3'(walker_col);
        rsp.moved_dir <= moved;
        rsp.move_total <= move_counter;
        rsp.stack_level <= 5'(stack_pointer);
        rsp.fault <= fault;
        rsp.at_exit <= exit_flag;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_data = rsp;
  assign in_stall = (state != S_IDLE);

  logic empty_fault;
  assign empty_fault = out_valid && out_data.fault == FAULT_EMPTY;

  `CHK_IMPL(a_busy_stall, clk, rst, state != S_IDLE, in_stall, "stall low while busy")
  `CHK_IMPL(a_sp_range, clk, rst, 1'b1, stack_pointer <= PW'(STACK_DEPTH), "stack overrun")
  `CHK_IMPL(a_fault_stay, clk, rst, empty_fault, out_data.moved_dir == DIR_NONE, "empty fault with a move")
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
endmodule

// ----- dv/tb_maze_junction_stack_walker_core.sv -----
// Testbench for the maze junction stack walker core: directed and random requests.
`timescale 1ns / 1ps

module tb_maze_junction_stack_walker_core;
  import mjsw_pkg::*;

  localparam int NR = ROWS_DEF;
  localparam int NC = COLS_DEF;
  localparam int NSTK = STACK_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    int unsigned row;
    int unsigned col;
    bit          explored[4];
    logic [2:0]  target;
  } junction_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  req_t   in_data = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  rsp_t   out_data;

  maze_junction_stack_walker_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Walker state as predicted from the accepted requests.
  logic [2:0]   grid [NR*NC];
  int unsigned  w_row = 0;
  int unsigned  w_col = 0;
  logic [2:0]   w_last = DIR_NONE;
  junction_t    jstack [NSTK];
  int unsigned  jsp = 0;
  int unsigned  moves = 0;

  rsp_t         pending_rsp [$];
  int           mismatches = 0;
  int unsigned  cycles = 0;
  bit           hold_out = 1'b0;
  int unsigned  hold_cycles = 0;

  // Off-map cells read as walls, like the block's bound check.
  function automatic logic [2:0] grid_at(int unsigned r, int unsigned c);
    if (r >= NR || c >= NC) return CELL_WALL;
    return grid[r*NC + c];
  endfunction

  function automatic bit step_to(logic [2:0] d, output int unsigned r,
                                 output int unsigned c);
    r = w_row;
    c = w_col;
    case (d)
      DIR_UP: begin if (w_row == 0) return 0; r = w_row - 1; end
      DIR_DOWN: begin if (w_row + 1 >= NR) return 0; r = w_row + 1; end
      DIR_LEFT: begin if (w_col == 0) return 0; c = w_col - 1; end
      default: begin if (w_col + 1 >= NC) return 0; c = w_col + 1; end
    endcase
    return 1;
  endfunction

  function automatic bit open_toward(logic [2:0] d);
    int unsigned r, c;
    if (!step_to(d, r, c)) return 0;
    return grid_at(r, c) != CELL_WALL;
  endfunction

  function automatic logic [2:0] probe(int i);
    case (i)
      0: return DIR_LEFT;
      1: return DIR_UP;
      2: return DIR_DOWN;
      default: return DIR_RIGHT;
    endcase
  endfunction

  function automatic void bump_moves();
    if (moves < 65535) moves++;
  endfunction

  // Advance the walker by one move request; return direction, set fault.
  function automatic logic [2:0] walk_one(output logic [1:0] flt);
    logic [2:0]  cur, dir, d;
    int unsigned r, c;
    cur = grid_at(w_row, w_col);
    dir = DIR_NONE;
    flt = FAULT_NONE;
    if (cur == CELL_EXIT) return DIR_NONE;
    if (cur == CELL_JUNCTION && jsp > 0) begin
      for (int i = 0; i < 4; i++) begin
        d = probe(i);
        if (open_toward(d) && jstack[jsp-1].target != d && !jstack[jsp-1].explored[d]) begin
          dir = d;
          break;
        end
      end
      if (dir != DIR_NONE) jstack[jsp-1].target = dir;
      else jsp--;
    end else begin
      for (int i = 0; i < 4; i++) begin
        d = probe(i);
        if (open_toward(d) && w_last != (d ^ 3'd1)) begin
          dir = d;
          break;
        end
      end
      if (dir != DIR_NONE) begin
        void'(step_to(dir, r, c));
        if (grid_at(r, c) == CELL_JUNCTION) begin
          if (jsp < NSTK) begin
            jstack[jsp].row = r;
            jstack[jsp].col = c;
            jstack[jsp].explored = '{0, 0, 0, 0};
            jstack[jsp].explored[dir ^ 3'd1] = 1;
            jstack[jsp].target = DIR_NONE;
            jsp++;
          end else begin
            flt = FAULT_FULL;
          end
        end
      end
    end
    if (dir != DIR_NONE) begin
      void'(step_to(dir, r, c));
      w_row = r;
      w_col = c;
      w_last = dir;
      bump_moves();
      return dir;
    end
    if (jsp == 0) begin
      flt = FAULT_EMPTY;
      return DIR_NONE;
    end
    // Dead end: jump back to the top junction.
    w_row = jstack[jsp-1].row;
    w_col = jstack[jsp-1].col;
    if (jstack[jsp-1].target < DIR_NONE) jstack[jsp-1].explored[jstack[jsp-1].target] = 1;
    bump_moves();
    return DIR_NONE;
  endfunction

  function automatic rsp_t predict_walker(req_t rq);
    rsp_t       rs;
    logic [2:0] dir;
    logic [1:0] flt;
    dir = DIR_NONE;
    flt = FAULT_NONE;
    case (rq.op)
      OP_LOAD: begin
        if (rq.cell_row < NR && rq.cell_col < NC)
          grid[rq.cell_row*NC + rq.cell_col] = rq.cell_code;
      end
      OP_PLACE: begin
        bit found;
        found = 0;
        w_row = NR - 1;
        w_col = 0;
        for (int r = 0; r < NR && !found; r++)
          for (int c = 0; c < NC && !found; c++)
            if (grid_at(r, c) == CELL_START) begin
              w_row = r;
              w_col = c;
              found = 1;
            end
        w_last = DIR_NONE;
        jsp = 0;
        moves = 0;
      end
      OP_MOVE: dir = walk_one(flt);
      default: ;
    endcase
    rs.pos_row = w_row[2:0];
    rs.pos_col = w_col[2:0];
    rs.moved_dir = dir;
    rs.move_total = moves[15:0];
    rs.at_exit = grid_at(w_row, w_col) == CELL_EXIT;
    rs.stack_level = jsp[4:0];
    rs.fault = flt;
    return rs;
  endfunction

  // Send one request at the falling edge and hold it until accepted.
  task automatic send_request(req_t rq);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_rsp.insert(pending_rsp.size(), predict_walker(rq));
    @(negedge clk);
  endtask

  // Check every result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        rsp_t want;
        want = pending_rsp.pop_front();
        if (want !== out_data) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // Receiver stalls; a hold-off forces a long stretch of stall.
  always @(negedge clk) begin
    if (hold_out) begin
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 19) == 0) begin
      out_stall <= 1'b1;
      hold_cycles = $urandom_range(5, 25);
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 5) == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[maze_junction_stack_walker_core] ERROR");
      $finish;
    end
  end

  function automatic req_t mk(logic [1:0] op, int r, int c, logic [2:0] code);
    req_t rq;
    rq.op = op;
    rq.cell_row = r[2:0];
    rq.cell_col = c[2:0];
    rq.cell_code = code;
    return rq;
  endfunction

  // Fill the whole grid so that no unwritten cell is ever read.
  task automatic load_grid(int wall_pct, int junc_pct, bit with_start, bit with_exit);
    int          v;
    logic [2:0]  code;
    for (int r = 0; r < NR; r++)
      for (int c = 0; c < NC; c++) begin
        v = $urandom_range(0, 99);
        if (v < wall_pct) code = CELL_WALL;
        else if (v < wall_pct + junc_pct) code = CELL_JUNCTION;
        else if (v < wall_pct + junc_pct + 3) code = 3'($urandom_range(5, 7));
        else code = CELL_OPEN;
        send_request(mk(OP_LOAD, r, c, code));
      end
    if (with_start)
      send_request(mk(OP_LOAD, $urandom_range(0, NR-1), $urandom_range(0, NC-1), CELL_START));
    if (with_exit)
      send_request(mk(OP_LOAD, $urandom_range(0, NR-1), $urandom_range(0, NC-1), CELL_EXIT));
  endtask

  task automatic test_directed();
    // Corridor along the top row and down the right column, walls elsewhere.
    for (int r = 0; r < NR; r++)
      for (int c = 0; c < NC; c++)
        send_request(mk(OP_LOAD, r, c, (r == 0 || c == NC-1) ? CELL_OPEN : CELL_WALL));
    send_request(mk(OP_MOVE, 0, 0, CELL_OPEN));     // move before place
    send_request(mk(OP_PLACE, 0, 0, CELL_OPEN));    // no start: bottom-left
    send_request(mk(OP_MOVE, 0, 0, CELL_OPEN));     // walled in, empty stack
    send_request(mk(OP_NOP, 7, 7, 3'd7));           // unknown op
    send_request(mk(OP_LOAD, 0, 0, CELL_START));
    send_request(mk(OP_LOAD, 0, 3, CELL_JUNCTION));
    send_request(mk(OP_LOAD, 1, 3, 3'd5));
    send_request(mk(OP_LOAD, 2, 3, 3'd7));
    send_request(mk(OP_LOAD, 7, 7, CELL_EXIT));
    send_request(mk(OP_PLACE, 7, 7, 3'd6));
    repeat (16) send_request(mk(OP_MOVE, 7, 7, 3'd7));
  endtask

  // Random mazes, each placed and walked for a while, plus noise requests.
  task automatic test_random_walks(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      load_grid($urandom_range(10, 45), $urandom_range(5, 40),
                $urandom_range(0, 3) != 0, $urandom_range(0, 2) != 0);
      sent += NR*NC + 2;
      send_request(mk(OP_PLACE, $urandom, $urandom, 3'($urandom)));
      repeat ($urandom_range(10, 60)) begin
        case ($urandom_range(0, 19))
          0: send_request(mk(OP_LOAD, $urandom, $urandom, 3'($urandom)));
          1: send_request(mk(OP_NOP, $urandom, $urandom, 3'($urandom)));
          2: send_request(mk(OP_PLACE, $urandom, $urandom, 3'($urandom)));
          default: send_request(mk(OP_MOVE, $urandom, $urandom, 3'($urandom)));
        endcase
        sent++;
      end
    end
  endtask

  // Open grid with junctions on every other cell so the stack fills past its depth.
  task automatic test_stack_full();
    for (int r = 0; r < NR; r++)
      for (int c = 0; c < NC; c++)
        send_request(mk(OP_LOAD, r, c, ((r + c) % 2) ? CELL_JUNCTION : CELL_OPEN));
    send_request(mk(OP_PLACE, 0, 0, CELL_OPEN));
    repeat (80) send_request(mk(OP_MOVE, 0, 0, CELL_OPEN));
  endtask

  // Hold the receiver off while requests keep coming, so the block backs up.
  task automatic test_output_holdoff();
    fork
      begin
        hold_out = 1'b1;
        repeat (200) @(posedge clk);
        hold_out = 1'b0;
      end
      repeat (12) send_request(mk(OP_MOVE, 0, 0, CELL_OPEN));
    join
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_stack_full();
    test_output_holdoff();
    test_random_walks(1600);
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0)
      $display("[maze_junction_stack_walker_core] OK");
    else
      $display("[maze_junction_stack_walker_core] ERROR");
    $finish;
  end

endmodule

// ----- maze_junction_stack_walker_core.f -----
+incdir+rtl
rtl/mjsw_pkg.sv
rtl/mjsw_ram.sv
rtl/maze_junction_stack_walker_core.sv
dv/tb_maze_junction_stack_walker_core.sv
